// ===== rtl/core/fl_pkg.sv =====
// ----------------------------------------------------------------------------
// fl_pkg
// Shared constants, request codes and controller/datapath bundles for the
// faulty line table.
// ----------------------------------------------------------------------------
package fl_pkg;

    // Default sizing of the table.
    localparam int DEF_ENTRIES   = 64;
    localparam int DEF_ADDR_BITS = 48;

    // Line size register.
    localparam int              LSL_W     = 4;
    localparam logic [LSL_W-1:0] LSL_RESET = 4'd6;

    // Request modes.
    localparam int              MODE_W         = 2;
    localparam logic [MODE_W-1:0] MODE_QUERY     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MARK      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MARK_PERM = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNMARK    = 2'd3;

    // Result word width: is_fault, is_permanent, table_full, zero padded.
    localparam int RES_W = 3;
    localparam int OUT_W = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;    // capture the request word and reset the search
        logic idx_clr;  // return the entry counter to zero
        logic idx_inc;  // step the entry counter
        logic rd;       // read the entry at the counter
        logic clr_wr;   // invalidate the entry at the counter
        logic upd;      // write back the search outcome and load the result
    } fl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_idx; // counter is at the final entry
        logic out_free; // result register can take a new word
    } fl_sts_t;

endpackage

// ===== rtl/core/fl_datapath.sv =====
// ----------------------------------------------------------------------------
// fl_datapath
// Entry memory, entry counter, line compare, search tracking, write-back
// logic and the result register of the faulty line table.
// ----------------------------------------------------------------------------
module fl_datapath #(
    parameter int ENTRIES   = fl_pkg::DEF_ENTRIES,
    parameter int ADDR_BITS = fl_pkg::DEF_ADDR_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fl_pkg::fl_cmd_t            cmd,
    output fl_pkg::fl_sts_t            sts,
    input  logic                       cfg_we,
    input  logic [fl_pkg::LSL_W-1:0]   cfg_wdata,
    input  logic [fl_pkg::MODE_W-1:0]  req_mode,
    input  logic [ADDR_BITS-1:0]       req_address,
    input  logic                       res_ready,
    output logic                       res_valid,
    output logic [fl_pkg::RES_W-1:0]   res_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // Entry layout: [0] fault, [1] permanent, line, then valid on top.
    localparam int ENT_W = ADDR_BITS + 3;
    localparam int VLD_B = ADDR_BITS + 2;

    logic [ENT_W-1:0]           mem [ENTRIES];
    logic [ENT_W-1:0]           rd_data_reg;
    logic                       rd_valid_reg;
    logic [IDX_W-1:0]           rd_idx_reg;
    logic [IDX_W-1:0]           idx_reg;

    logic [fl_pkg::LSL_W-1:0]   lsl_reg;
    logic [fl_pkg::MODE_W-1:0]  mode_reg;
    logic [ADDR_BITS-1:0]       line_reg;

    logic                       found_reg;
    logic [IDX_W-1:0]           found_idx_reg;
    logic                       found_f_reg;
    logic                       found_p_reg;
    logic                       free_reg;
    logic [IDX_W-1:0]           free_idx_reg;

    logic                       out_valid_reg;
    logic [fl_pkg::RES_W-1:0]   out_data_reg;

    logic [ADDR_BITS-1:0]       line_mask;
    logic                       e_valid;
    logic                       e_hit;
    logic                       new_f;
    logic                       new_p;
    logic                       full;
    logic                       wr_hit;
    logic [IDX_W-1:0]           upd_idx;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_idx;
    logic [ENT_W-1:0]           wr_data;
    logic                       is_mark;

    // Line size register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lsl_reg <= fl_pkg::LSL_RESET;
        end else if (cfg_we) begin
            lsl_reg <= cfg_wdata;
        end
    end

    assign line_mask = {ADDR_BITS{1'b1}} << lsl_reg;

    // Request capture.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            mode_reg <= req_mode;
            line_reg <= req_address & line_mask;
        end
    end

    // Entry counter, shared by the clearing pass and the search.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    assign sts.last_idx = (idx_reg == IDX_W'(ENTRIES - 1));

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_data_reg <= mem[idx_reg];
            rd_idx_reg  <= idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.rd;
        end
    end

    // Compare of the entry read in the previous cycle.
    assign e_valid = rd_data_reg[VLD_B];
    assign e_hit   = e_valid && (rd_data_reg[VLD_B-1:2] == line_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end else if (cmd.start) begin
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end else if (rd_valid_reg) begin
            if (e_hit && !found_reg) begin
                found_reg <= 1'b1;
            end
            if (!e_valid && !free_reg) begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg && e_hit && !found_reg) begin
            found_idx_reg <= rd_idx_reg;
            found_f_reg   <= rd_data_reg[0];
            found_p_reg   <= rd_data_reg[1];
        end
        if (rd_valid_reg && !e_valid && !free_reg) begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    // Outcome of the search: new bits of the line and the entry to write.
    assign is_mark = (mode_reg == fl_pkg::MODE_MARK) || (mode_reg == fl_pkg::MODE_MARK_PERM);

    always_comb begin
        new_f   = 1'b0;
        new_p   = 1'b0;
        full    = 1'b0;
        wr_hit  = 1'b0;
        upd_idx = found_idx_reg;
        if (found_reg) begin
            new_f = found_f_reg;
            new_p = found_p_reg;
            case (mode_reg)
                fl_pkg::MODE_MARK:      new_f = 1'b1;
                fl_pkg::MODE_MARK_PERM: new_p = 1'b1;
                fl_pkg::MODE_UNMARK:    new_f = 1'b0;
                default:                new_f = found_f_reg;
            endcase
            wr_hit = (mode_reg != fl_pkg::MODE_QUERY);
        end else if (is_mark) begin
            if (free_reg) begin
                new_f   = (mode_reg == fl_pkg::MODE_MARK);
                new_p   = (mode_reg == fl_pkg::MODE_MARK_PERM);
                wr_hit  = 1'b1;
                upd_idx = free_idx_reg;
            end else begin
                full = 1'b1;
            end
        end
    end

    // An entry whose bits are both clear is written back as invalid.
    assign wr_en   = cmd.clr_wr || (cmd.upd && wr_hit);
    assign wr_idx  = cmd.clr_wr ? idx_reg : upd_idx;
    assign wr_data = cmd.clr_wr ? '0 : {(new_f | new_p), line_reg, new_p, new_f};

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.upd) begin
            out_valid_reg <= 1'b1;
        end else if (res_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            out_data_reg <= {full, new_p, new_f};
        end
    end

    assign sts.out_free = !out_valid_reg || res_ready;
    assign res_valid    = out_valid_reg;
    assign res_data     = out_data_reg;

endmodule

// ===== rtl/core/fl_ctrl.sv =====
// ----------------------------------------------------------------------------
// fl_ctrl
// Sequencer of the faulty line table: clearing pass, request acceptance,
// entry search, drain of the last compare and write-back.
// ----------------------------------------------------------------------------
module fl_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             req_valid,
    output logic             req_ready,
    input  fl_pkg::fl_sts_t  sts,
    output fl_pkg::fl_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.last_idx) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_IDLE: begin
                if (req_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.rd = 1'b1;
                if (sts.last_idx) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_DRAIN;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (sts.out_free) begin
                    cmd.upd    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/core/faulty_line_table.sv =====
// ----------------------------------------------------------------------------
// faulty_line_table
// Table of faulty memory lines with fault and permanent marks, looked up by
// line-aligned address.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents (lowest bit first)
//  s_axis    in         mode[1:0], address[ADDR_BITS-1:0], zero padding
//  m_axis    out        is_fault, is_permanent, table_full, zero padding
//  cfg       in         line_size_log2[3:0], written while cfg_we is high
//
// Each request word is captured when it is accepted; the entry memory is then
// walked entry by entry through its single read port, a drain state takes the
// last compare and an update state does the write-back. Only then can the
// next word be accepted.
// After reset the block runs a clearing pass over every entry of the entry
// memory, during which s_axis_tready stays low; configuration writes are
// taken during that pass.
// The result register frees the input side: a new request is accepted and
// searched while the previous result waits on m_axis_tready, and only the
// write-back waits for the result register to empty.
// ----------------------------------------------------------------------------
module faulty_line_table #(
    parameter int ENTRIES   = fl_pkg::DEF_ENTRIES,
    parameter int ADDR_BITS = fl_pkg::DEF_ADDR_BITS,
    // Request word width, rounded up to whole bytes.
    parameter int IN_W      = ((fl_pkg::MODE_W + ADDR_BITS + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    // Request channel.
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // Fields from bit 0: mode (2 bits), address (ADDR_BITS bits), padding.
    input  logic [IN_W-1:0]           s_axis_tdata,

    // Result channel.
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // Fields from bit 0: is_fault, is_permanent, table_full, padding.
    output logic [fl_pkg::OUT_W-1:0]  m_axis_tdata,

    // Line size register.
    input  logic                      cfg_we,
    input  logic [fl_pkg::LSL_W-1:0]  cfg_wdata
);

    fl_pkg::fl_cmd_t              cmd;
    fl_pkg::fl_sts_t              sts;
    logic [fl_pkg::RES_W-1:0]     res_data;

    // The controller owns the request handshake; the datapath captures the
    // request word whenever the controller issues its start command, which
    // is exactly the accepting edge.
    fl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fl_datapath #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_mode    (s_axis_tdata[fl_pkg::MODE_W-1:0]),
        .req_address (s_axis_tdata[fl_pkg::MODE_W +: ADDR_BITS]),
        .res_ready   (m_axis_tready),
        .res_valid   (m_axis_tvalid),
        .res_data    (res_data)
    );

    // Unused upper bits of the result word are driven to zero.
    assign m_axis_tdata = {{(fl_pkg::OUT_W - fl_pkg::RES_W){1'b0}}, res_data};

endmodule

// ===== rtl/core/fl_checker.sv =====
// ----------------------------------------------------------------------------
// fl_checker
// Port-level checks of the faulty line table, bound to the top level.
// ----------------------------------------------------------------------------
module fl_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [fl_pkg::OUT_W-1:0]  m_axis_tdata
);

    // A stalled result word keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // A dropped mark reports the line as unmarked.
    a_full_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[0] && !m_axis_tdata[1])
        else $error("table_full with a mark bit set");

    // Padding of the result word is zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[fl_pkg::OUT_W-1:fl_pkg::RES_W] == '0)
        else $error("result padding not zero");

    // One request is searched at a time: acceptance is followed by a busy cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted during a search");

endmodule

bind faulty_line_table fl_checker u_fl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
